/* hdl/sacp_pkg.sv */
// Shared types and constants for the set-associative cache with prefetch.
package sacp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;
    localparam int STAMP_W = 32;
    localparam int CNT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LRU_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_ON = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLR   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_WRITE = 6'b001000,
        S_PREF  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic       lru_mode;
        logic       prefetch_on;
        logic [3:0] offset_bits;
        logic [3:0] index_bits;
        logic [4:0] ways_in_use;
    } t_cfg;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

/* hdl/sacp_tag_mem.sv */
// Valid, tag and age-stamp memory with one write port and one registered read port.
module sacp_tag_mem import sacp_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int TAG_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic                     i_wvalid,
    input  logic [TAG_W-1:0]         i_wtag,
    input  logic [STAMP_W-1:0]       i_wstamp,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic                     o_rvalid,
    output logic [TAG_W-1:0]         o_rtag,
    output logic [STAMP_W-1:0]       o_rstamp
);
    logic [TAG_W+STAMP_W:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wvalid, i_wtag, i_wstamp};
        end
        {o_rvalid, o_rtag, o_rstamp} <= mem[i_raddr];
    end
endmodule

/* hdl/set_assoc_cache_with_prefetch_unit.sv */
// Top level of the set-associative cache tag model with next-line prefetch.
// Each item looks up its set by scanning its ways out of a single valid/tag/stamp
// memory, one way per cycle; a miss with prefetch on then scans the next line's set
// the same way. The way scan through the single read port sets the time. After reset
// a clearing pass over all MAX_SETS * MAX_WAYS entries (4096 by default) invalidates
// every line while the input is not ready. Results wait in an output register.
module set_assoc_cache_with_prefetch_unit import sacp_pkg::*; #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 16,
    parameter int ADDR_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [ADDR_BITS-1:0]  i_address,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output logic [1:0]            o_mem_reads,
    output logic                  o_mem_write,
    output logic [CNT_W-1:0]      o_hit_total,
    output logic [CNT_W-1:0]      o_miss_total,
    output logic [CNT_W-1:0]      o_read_total,
    output logic [CNT_W-1:0]      o_write_total
);
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SBITS = $clog2(MAX_SETS + 1) - 1;
    localparam int DEPTH = MAX_SETS * MAX_WAYS;
    localparam int ENT_W = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1) > 5 ? $clog2(MAX_WAYS + 1) : 5;

    t_cfg r_cfg;
    t_state r_state;
    logic [ENT_W-1:0] r_clr;
    logic [STAMP_W-1:0] r_stamp_ctr;
    logic [CNT_W-1:0] r_hits, r_misses, r_reads, r_writes;
    logic r_cmd;
    logic [ADDR_BITS-1:0] r_addr;
    logic r_pf;
    logic [SET_W-1:0] r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [WCNT_W-1:0] r_way;
    logic r_rd;
    logic [WAY_W-1:0] r_rway;
    logic r_found, r_free_f;
    logic [WAY_W-1:0] r_match, r_free, r_vict;
    logic [STAMP_W-1:0] r_best;
    logic r_best_ok;
    logic r_dhit;
    logic [1:0] r_nreads;

    logic mvalid;
    logic [ADDR_BITS-1:0] mtag;
    logic [STAMP_W-1:0] mstamp;
    logic mem_we;
    logic wvalid;
    logic [ENT_W-1:0] waddr, raddr;
    logic [STAMP_W-1:0] wstamp;
    logic [WCNT_W-1:0] ways;
    logic [3:0] ib;

    always_comb begin
        ways = WCNT_W'(r_cfg.ways_in_use);
        if (ways == '0) ways = WCNT_W'(1);
        if (ways > WCNT_W'(MAX_WAYS)) ways = WCNT_W'(MAX_WAYS);
        ib = (int'(r_cfg.index_bits) > SBITS) ? 4'(SBITS) : r_cfg.index_bits;
    end

    function automatic logic [SET_W-1:0] f_set(input logic [ADDR_BITS-1:0] a,
                                               input logic [3:0] ob,
                                               input logic [3:0] b);
        logic [ADDR_BITS-1:0] blk;
        blk = a >> ob;
        return SET_W'(blk & ((ADDR_BITS'(1) << b) - ADDR_BITS'(1)));
    endfunction

    function automatic logic [ENT_W-1:0] f_ent(input logic [SET_W-1:0] s,
                                               input logic [WAY_W-1:0] w);
        return ENT_W'(s) * ENT_W'(MAX_WAYS) + ENT_W'(w);
    endfunction

    logic [WAY_W-1:0] wsel;
    always_comb begin
        wsel = r_found ? r_match : (r_free_f ? r_free : r_vict);
        waddr = (r_state == S_CLR) ? r_clr : f_ent(r_set, wsel);
        raddr = f_ent(r_set, r_way[WAY_W-1:0]);
        wstamp = r_stamp_ctr + STAMP_W'(1);
        wvalid = (r_state != S_CLR);
        mem_we = (r_state == S_CLR) ||
                 ((r_state == S_WRITE) && (!r_found || (r_cfg.lru_mode && !r_pf)));
    end

    sacp_tag_mem #(.DEPTH(DEPTH), .TAG_W(ADDR_BITS)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(waddr), .i_wvalid(wvalid),
        .i_wtag(r_tag), .i_wstamp(wstamp), .i_raddr(raddr), .o_rvalid(mvalid),
        .o_rtag(mtag), .o_rstamp(mstamp)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{lru_mode: 1'b0, prefetch_on: 1'b0, offset_bits: 4'd6,
                       index_bits: 4'd4, ways_in_use: 5'd16};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data[3:0];
                REG_INDEX_BITS:  r_cfg.index_bits <= i_cfg_data[3:0];
                REG_WAYS_IN_USE: r_cfg.ways_in_use <= i_cfg_data;
                REG_LRU_MODE:    r_cfg.lru_mode <= i_cfg_data[0];
                REG_PREFETCH_ON: r_cfg.prefetch_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_stamp_ctr <= '0;
            r_hits <= '0;
            r_misses <= '0;
            r_reads <= '0;
            r_writes <= '0;
            r_rd <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + ENT_W'(1);
                    if (r_clr == ENT_W'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_addr <= i_address;
                        r_pf <= 1'b0;
                        r_nreads <= '0;
                        r_dhit <= 1'b0;
                        r_set <= f_set(i_address, r_cfg.offset_bits, ib);
                        r_tag <= i_address >> (5'(r_cfg.offset_bits) + 5'(ib));
                        r_way <= '0;
                        r_found <= 1'b0;
                        r_free_f <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_vict <= '0;
                        r_rd <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd <= (r_way < ways);
                    if (r_rd) begin
                        if (mvalid) begin
                            if (mtag == r_tag && !r_found) begin
                                r_found <= 1'b1;
                                r_match <= r_rway;
                            end
                            if (!r_best_ok || mstamp < r_best) begin
                                r_best <= mstamp;
                                r_best_ok <= 1'b1;
                                r_vict <= r_rway;
                            end
                        end else if (!r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free <= r_rway;
                        end
                    end
                    if (r_way < ways) begin
                        r_rway <= r_way[WAY_W-1:0];
                        r_way <= r_way + WCNT_W'(1);
                    end else if (!r_rd) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (!r_pf) begin
                        if (r_found) begin
                            r_dhit <= 1'b1;
                            if (r_cfg.lru_mode) r_stamp_ctr <= wstamp;
                            r_state <= S_OUT;
                        end else begin
                            r_stamp_ctr <= wstamp;
                            r_nreads <= 2'd1;
                            r_state <= r_cfg.prefetch_on ? S_PREF : S_OUT;
                        end
                    end else begin
                        if (!r_found) begin
                            r_stamp_ctr <= wstamp;
                            r_nreads <= 2'd2;
                        end
                        r_state <= S_OUT;
                    end
                    if (r_state == S_WRITE && (r_pf || r_found ||
                                               !r_cfg.prefetch_on)) begin
                        r_hits <= sat_add(r_hits, {1'b0, r_found & !r_pf});
                        r_misses <= sat_add(r_misses, {1'b0, !(r_found & !r_pf)});
                        r_reads <= sat_add(r_reads, r_pf ? (r_found ? 2'd1 : 2'd2)
                                                         : (r_found ? 2'd0 : 2'd1));
                        r_writes <= sat_add(r_writes, {1'b0, r_cmd});
                    end
                end
                S_PREF: begin
                    r_pf <= 1'b1;
                    r_addr <= r_addr + (ADDR_BITS'(1) << r_cfg.offset_bits);
                    r_set <= f_set(r_addr + (ADDR_BITS'(1) << r_cfg.offset_bits),
                                   r_cfg.offset_bits, ib);
                    r_tag <= (r_addr + (ADDR_BITS'(1) << r_cfg.offset_bits))
                             >> (5'(r_cfg.offset_bits) + 5'(ib));
                    r_way <= '0;
                    r_found <= 1'b0;
                    r_free_f <= 1'b0;
                    r_best_ok <= 1'b0;
                    r_vict <= '0;
                    r_rd <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_hit = r_dhit;
    assign o_mem_reads = r_nreads;
    assign o_mem_write = r_cmd;
    assign o_hit_total = r_hits;
    assign o_miss_total = r_misses;
    assign o_read_total = r_reads;
    assign o_write_total = r_writes;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit_total))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");
    a_reads_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_mem_reads == 2'd0)
        else $error("hit caused memory read");
endmodule

/* tb/cache_checker.sv */
// Checker: watches both channels, predicts each cache access result and compares.
`timescale 1ns / 1ps
module cache_checker import sacp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_ready_in,
    input  logic                  i_cmd,
    input  logic [47:0]           i_address,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_hit,
    input  logic [1:0]            i_mem_reads,
    input  logic                  i_mem_write,
    input  logic [31:0]           i_hit_total,
    input  logic [31:0]           i_miss_total,
    input  logic [31:0]           i_read_total,
    input  logic [31:0]           i_write_total,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_hits,
    output int                    o_prefetches
);
    localparam int NSETS = 256;
    localparam int NWAYS = 16;

    typedef struct packed {
        logic        hit;
        logic [1:0]  reads;
        logic        wr;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] rd_tot;
        logic [31:0] wr_tot;
    } t_access_result;

    t_access_result expected_results[$];
    logic [47:0] line_tag [NSETS*NWAYS];
    logic        line_valid [NSETS*NWAYS];
    logic [31:0] line_stamp [NSETS*NWAYS];
    logic [31:0] stamp_ctr, hit_cnt, miss_cnt, rd_cnt, wr_cnt;
    logic [3:0]  c_off, c_idx;
    logic [4:0]  c_ways;
    logic        c_lru, c_pref;

    function automatic int eff_ways();
        if (c_ways == 0) return 1;
        if (c_ways > NWAYS) return NWAYS;
        return int'(c_ways);
    endfunction

    function automatic void split_addr(input logic [47:0] a, output int set,
                                       output logic [47:0] tag);
        int ib;
        logic [47:0] blk;
        ib = c_idx > 8 ? 8 : c_idx;
        blk = a >> c_off;
        set = int'(blk & ((48'd1 << ib) - 48'd1));
        tag = a >> (c_off + ib);
    endfunction

    function automatic int find_way(input int set, input logic [47:0] tag);
        for (int w = 0; w < eff_ways(); w++)
            if (line_valid[set*NWAYS+w] && line_tag[set*NWAYS+w] == tag) return w;
        return -1;
    endfunction

    function automatic void fill_line(input int set, input logic [47:0] tag);
        int victim;
        logic [31:0] best;
        victim = -1;
        for (int w = 0; w < eff_ways(); w++)
            if (victim < 0 && !line_valid[set*NWAYS+w]) victim = w;
        if (victim < 0) begin
            victim = 0;
            best = line_stamp[set*NWAYS];
            for (int w = 1; w < eff_ways(); w++)
                if (line_stamp[set*NWAYS+w] < best) begin
                    best = line_stamp[set*NWAYS+w];
                    victim = w;
                end
        end
        stamp_ctr++;
        line_tag[set*NWAYS+victim] = tag;
        line_valid[set*NWAYS+victim] = 1'b1;
        line_stamp[set*NWAYS+victim] = stamp_ctr;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [1:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_access_result predict_access(input logic wr, input logic [47:0] a);
        t_access_result r;
        int set, set2, way;
        logic [47:0] tag, tag2;
        r = '0;
        split_addr(a, set, tag);
        way = find_way(set, tag);
        if (way >= 0) begin
            r.hit = 1'b1;
            if (c_lru) begin
                stamp_ctr++;
                line_stamp[set*NWAYS+way] = stamp_ctr;
            end
            hit_cnt = sat_inc(hit_cnt, 2'd1);
        end else begin
            miss_cnt = sat_inc(miss_cnt, 2'd1);
            fill_line(set, tag);
            r.reads = 2'd1;
            if (c_pref) begin
                split_addr(a + (48'd1 << c_off), set2, tag2);
                if (find_way(set2, tag2) < 0) begin
                    fill_line(set2, tag2);
                    r.reads = 2'd2;
                end
            end
        end
        rd_cnt = sat_inc(rd_cnt, r.reads);
        if (wr) wr_cnt = sat_inc(wr_cnt, 2'd1);
        r.wr = wr;
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.rd_tot = rd_cnt;
        r.wr_tot = wr_cnt;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_access_result e, got;
        if (!i_rst_n) begin
            for (int i = 0; i < NSETS*NWAYS; i++) line_valid[i] = 1'b0;
            stamp_ctr = 0; hit_cnt = 0; miss_cnt = 0; rd_cnt = 0; wr_cnt = 0;
            c_off = 4'd6; c_idx = 4'd4; c_ways = 5'd16; c_lru = 0; c_pref = 0;
            expected_results.delete();
            o_errors <= 0; o_results <= 0; o_hits <= 0; o_prefetches <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_BITS: c_off = i_cfg_data[3:0];
                    REG_INDEX_BITS:  c_idx = i_cfg_data[3:0];
                    REG_WAYS_IN_USE: c_ways = i_cfg_data[4:0];
                    REG_LRU_MODE:    c_lru = i_cfg_data[0];
                    REG_PREFETCH_ON: c_pref = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_hit, i_mem_reads, i_mem_write, i_hit_total, i_miss_total,
                       i_read_total, i_write_total};
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e !== got) begin
                        $display("%0t: mismatch expected hit=%0d rd=%0d wr=%0d h=%0d m=%0d r=%0d w=%0d",
                                 $time, e.hit, e.reads, e.wr, e.hits, e.misses, e.rd_tot, e.wr_tot);
                        $display("%0t:          actual hit=%0d rd=%0d wr=%0d h=%0d m=%0d r=%0d w=%0d",
                                 $time, got.hit, got.reads, got.wr, got.hits, got.misses,
                                 got.rd_tot, got.wr_tot);
                        o_errors <= o_errors + 1;
                    end
                    if (e.hit) o_hits <= o_hits + 1;
                    if (e.reads == 2) o_prefetches <= o_prefetches + 1;
                end
            end
            if (i_valid && i_ready_in)
                expected_results.push_back(predict_access(i_cmd, i_address));
        end
    end
endmodule

/* tb/tb.sv */
// Testbench top: drives cache accesses and configuration, reports the verdict.
`timescale 1ns / 1ps
module tb;
    import sacp_pkg::*;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 0;
    logic                  o_ready;
    logic                  i_cmd = 0;
    logic [47:0]           i_address = '0;
    logic                  o_valid;
    logic                  i_ready = 0;
    logic                  o_hit, o_mem_write;
    logic [1:0]            o_mem_reads;
    logic [31:0]           o_hit_total, o_miss_total, o_read_total, o_write_total;
    int errors, pending, results, hits, prefetches;
    int send_gap, recv_gap;
    bit calm;

    always #1 i_clk = ~i_clk;

    set_assoc_cache_with_prefetch_unit uut (.*);

    cache_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid,
        .i_ready_in(o_ready), .i_cmd, .i_address, .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_hit(o_hit), .i_mem_reads(o_mem_reads),
        .i_mem_write(o_mem_write),
        .i_hit_total(o_hit_total), .i_miss_total(o_miss_total),
        .i_read_total(o_read_total), .i_write_total(o_write_total),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_hits(hits), .o_prefetches(prefetches)
    );

    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_ready <= i_rst_n;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 0;
        end else if ($urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 19);
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    task automatic send_access(input logic wr, input logic [47:0] a);
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_cmd <= wr;
        i_address <= a;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_pipe();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input int ob, input int ib, input int w, input int lru,
                                input int pf);
        write_reg(REG_OFFSET_BITS, ob);
        write_reg(REG_INDEX_BITS, ib);
        write_reg(REG_WAYS_IN_USE, w);
        write_reg(REG_LRU_MODE, lru);
        write_reg(REG_PREFETCH_ON, pf);
        i_cfg_we <= 0;
    endtask

    function automatic logic [47:0] rand_addr(input int mode);
        logic [47:0] a;
        a = 48'({$urandom, $urandom});
        if (mode == 0) return a;
        return a & 48'h3FFF;
    endfunction

    initial begin
        logic [47:0] a;
        int sel;
        calm = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, hits, FIFO vs LRU, prefetch wrap, single way
        send_access(0, 48'h0);
        send_access(1, 48'h0);
        send_access(1, 48'hFFFF_FFFF_FFFF);
        send_access(0, 48'hFFFF_FFFF_FFC0);
        send_access(0, 48'h0000_0000_0040);
        send_access(1, 48'hAAAA_AAAA_AAAA);
        send_access(0, 48'h5555_5555_5555);
        drain_pipe();
        set_geometry(0, 0, 1, 1, 1);
        send_access(0, 48'hFFFF_FFFF_FFFF);
        send_access(0, 48'h0);
        send_access(1, 48'h1);
        send_access(0, 48'h0);
        drain_pipe();
        set_geometry(12, 8, 16, 1, 1);
        send_access(0, 48'hFFFF_FFFF_F000);
        send_access(1, 48'h0);
        send_access(0, 48'h1000);
        drain_pipe();
        set_geometry(4, 15, 0, 0, 1);
        send_access(0, 48'h10);
        send_access(1, 48'h20);
        send_access(0, 48'h10);
        drain_pipe();
        set_geometry(2, 1, 31, 1, 0);
        for (int i = 0; i < 6; i++) send_access(i[0], 48'(i * 8));
        drain_pipe();

        for (int ph = 0; ph < 12; ph++) begin
            set_geometry($urandom_range(0, 12), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom_range(0, 1),
                         $urandom_range(0, 1));
            if (ph == 11) calm = 1;
            for (int i = 0; i < 150; i++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) a = rand_addr(0);
                else if (sel < 4) a = 48'hFFFF_FFFF_C000 | rand_addr(1);
                else a = rand_addr(1);
                send_access($urandom_range(0, 1), a);
            end
            drain_pipe();
        end

        $display("Covered %0d accesses over 17 cache geometries: %0d hits, %0d prefetch fills.",
                 results, hits, prefetches);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
hdl/sacp_pkg.sv
hdl/sacp_tag_mem.sv
hdl/set_assoc_cache_with_prefetch_unit.sv
tb/cache_checker.sv
tb/tb.sv
